FILE: hw/rtl/spm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spm_pkg: shared types, constants and helpers of the stage pacing monitor
// Holds the transaction layouts passed between pipeline stages, register
// indexes, request codes and the saturating delta functions.
// ----------------------------------------------------------------------------
package spm_pkg;

  // default parameter values
  localparam int NUM_STAGES_DEF = 8;
  localparam int COUNT_BITS_DEF = 32;

  // field widths fixed by the interface
  localparam int STAGE_W  = 3;
  localparam int STAMP_W  = 64;
  localparam int THRESH_W = 32;
  localparam int TOTAL_W  = 32;

  // configuration register indexes
  localparam int CFG_INDEX_W = 1;
  localparam logic [CFG_INDEX_W-1:0] CFG_CAPTURE_ENABLE = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_ANOMALY_THRESH = 1'd1;
  localparam logic [THRESH_W-1:0]    THRESH_RESET       = 32'd2000000;

  // request codes
  localparam logic REQ_OBSERVE = 1'b0;
  localparam logic REQ_CLEAR   = 1'b1;

  localparam logic [STAMP_W-1:0] SIGN64 = 64'h8000_0000_0000_0000;
  localparam logic [STAMP_W-1:0] SMAX64 = 64'h7FFF_FFFF_FFFF_FFFF;

  // one input transaction
  typedef struct packed {
    logic               req_type;
    logic [STAGE_W-1:0] stage_index;
    logic [STAMP_W-1:0] source_stamp;
    logic [STAMP_W-1:0] source_timecode;
    logic [STAMP_W-1:0] local_stamp;
    logic [STAMP_W-1:0] wall_time;
  } spm_item_t;

  // delta stage to anomaly stage
  typedef struct packed {
    logic               clear;
    logic               obs;
    logic [STAGE_W-1:0] stage_index;
    logic               priors_nz;
    logic [STAMP_W-1:0] local_delta;
    logic [STAMP_W-1:0] wall_time_delta;
    logic [STAMP_W-1:0] source_stamp_delta;
    logic [STAMP_W-1:0] source_timecode_delta;
    logic [TOTAL_W-1:0] observation_total;
  } spm_mid_t;

  // one result transaction
  typedef struct packed {
    logic               accepted;
    logic [STAMP_W-1:0] local_delta;
    logic [STAMP_W-1:0] wall_time_delta;
    logic [STAMP_W-1:0] source_stamp_delta;
    logic [STAMP_W-1:0] source_timecode_delta;
    logic               pacing_anomaly;
    logic [TOTAL_W-1:0] observation_total;
    logic [TOTAL_W-1:0] anomaly_total;
  } spm_result_t;

  // saturated signed change between two unsigned values
  function automatic logic [STAMP_W-1:0] udelta(input logic [STAMP_W-1:0] cur,
                                                input logic [STAMP_W-1:0] prev);
    logic [STAMP_W:0] d;
    logic [STAMP_W-1:0] r;
    d = {1'b0, cur} - {1'b0, prev};
    if (d[STAMP_W]) begin
      // negative change: saturate when magnitude exceeds 2^63
      r = d[STAMP_W-1] ? d[STAMP_W-1:0] : SIGN64;
    end else begin
      r = d[STAMP_W-1] ? SMAX64 : d[STAMP_W-1:0];
    end
    return r;
  endfunction

  // saturated signed change between two signed values
  function automatic logic [STAMP_W-1:0] sdelta(input logic [STAMP_W-1:0] cur,
                                                input logic [STAMP_W-1:0] prev);
    logic [STAMP_W-1:0] r;
    logic [STAMP_W-1:0] res;
    r = cur - prev;
    if ((cur[STAMP_W-1] ^ prev[STAMP_W-1]) & (cur[STAMP_W-1] ^ r[STAMP_W-1])) begin
      res = cur[STAMP_W-1] ? SIGN64 : SMAX64;
    end else begin
      res = r;
    end
    return res;
  endfunction

endpackage

FILE: hw/rtl/spm_delta_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spm_delta_stage: prior records and timestamp deltas
// Reads the stage's prior timestamps, forms four saturated deltas, stores
// new timestamps, bumps the observation counter; a clear wipes all records.
// ----------------------------------------------------------------------------
module spm_delta_stage #(
  parameter int NUM_STAGES = spm_pkg::NUM_STAGES_DEF,
  parameter int COUNT_BITS = spm_pkg::COUNT_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              capture_enable,
  input  logic              in_valid,
  input  spm_pkg::spm_item_t in_item,
  output logic              in_ready,
  output logic              mid_valid,
  output spm_pkg::spm_mid_t mid_item,
  input  logic              mid_ready
);

  localparam int IDX_BITS = (NUM_STAGES > 1) ? $clog2(NUM_STAGES) : 1;
  localparam int SW       = spm_pkg::STAGE_W;

  logic [spm_pkg::STAMP_W-1:0] prior_ss_r [NUM_STAGES];
  logic [spm_pkg::STAMP_W-1:0] prior_tc_r [NUM_STAGES];
  logic [spm_pkg::STAMP_W-1:0] prior_ls_r [NUM_STAGES];
  logic [spm_pkg::STAMP_W-1:0] prior_wt_r [NUM_STAGES];
  logic [COUNT_BITS-1:0]       obs_cnt_r  [NUM_STAGES];

  logic              mid_valid_r;
  spm_pkg::spm_mid_t mid_r;
  spm_pkg::spm_mid_t mid_nxt;

  logic                        take;
  logic                        in_range;
  logic                        is_clear;
  logic                        is_obs;
  logic [SW+IDX_BITS-1:0]      idx_wide;
  logic [IDX_BITS-1:0]         sel;
  logic [spm_pkg::STAMP_W-1:0] p_ss, p_tc, p_ls, p_wt;
  logic [COUNT_BITS-1:0]       cnt_nxt;
  logic [COUNT_BITS+31:0]      cnt_ext;

  // handshake
  assign in_ready  = !mid_valid_r || mid_ready;
  assign take      = in_valid && in_ready;
  assign mid_valid = mid_valid_r;
  assign mid_item  = mid_r;

  // stage decode and record read
  always_comb begin
    idx_wide = {{IDX_BITS{1'b0}}, in_item.stage_index};
    sel      = idx_wide[IDX_BITS-1:0];
    in_range = 32'(in_item.stage_index) < 32'(NUM_STAGES);
    is_clear = in_item.req_type == spm_pkg::REQ_CLEAR;
    is_obs   = (in_item.req_type == spm_pkg::REQ_OBSERVE) && capture_enable && in_range;
    p_ss     = prior_ss_r[sel];
    p_tc     = prior_tc_r[sel];
    p_ls     = prior_ls_r[sel];
    p_wt     = prior_wt_r[sel];
    cnt_nxt  = (&obs_cnt_r[sel]) ? obs_cnt_r[sel] : obs_cnt_r[sel] + 1'b1;
    cnt_ext  = {32'd0, cnt_nxt};
  end

  // deltas and forwarded transaction
  always_comb begin
    mid_nxt                       = '0;
    mid_nxt.clear                 = is_clear;
    mid_nxt.obs                   = is_obs;
    mid_nxt.stage_index           = in_item.stage_index;
    mid_nxt.priors_nz             = (p_ls != '0) && (p_wt != '0);
    mid_nxt.local_delta           = (p_ls != '0) ? spm_pkg::udelta(in_item.local_stamp, p_ls) : '0;
    mid_nxt.wall_time_delta       = (p_wt != '0) ? spm_pkg::udelta(in_item.wall_time, p_wt) : '0;
    mid_nxt.source_stamp_delta    = (p_ss != '0) ?
                                    spm_pkg::sdelta(in_item.source_stamp, p_ss) : '0;
    mid_nxt.source_timecode_delta = (p_tc != '0) ?
                                    spm_pkg::sdelta(in_item.source_timecode, p_tc) : '0;
    mid_nxt.observation_total     = (|cnt_ext[COUNT_BITS+31:32]) ? '1 : cnt_ext[31:0];
  end

  // stage records
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_STAGES; i++) begin
        prior_ss_r[i] <= '0;
        prior_tc_r[i] <= '0;
        prior_ls_r[i] <= '0;
        prior_wt_r[i] <= '0;
        obs_cnt_r[i]  <= '0;
      end
    end else if (take && is_clear) begin
      for (int i = 0; i < NUM_STAGES; i++) begin
        prior_ss_r[i] <= '0;
        prior_tc_r[i] <= '0;
        prior_ls_r[i] <= '0;
        prior_wt_r[i] <= '0;
        obs_cnt_r[i]  <= '0;
      end
    end else if (take && is_obs) begin
      prior_ss_r[sel] <= in_item.source_stamp;
      prior_tc_r[sel] <= in_item.source_timecode;
      prior_ls_r[sel] <= in_item.local_stamp;
      prior_wt_r[sel] <= in_item.wall_time;
      obs_cnt_r[sel]  <= cnt_nxt;
    end
  end

  // output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mid_valid_r <= 1'b0;
    end else if (take) begin
      mid_valid_r <= 1'b1;
    end else if (mid_ready) begin
      mid_valid_r <= 1'b0;
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (take) begin
      mid_r <= mid_nxt;
    end
  end

endmodule

FILE: hw/rtl/spm_anomaly_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spm_anomaly_stage: pacing anomaly check and result register
// Compares the gap between local and wall deltas against the threshold, also
// flags a zero or negative local delta, keeps the per-stage anomaly counters
// and registers the result transaction.
module spm_anomaly_stage #(
  parameter int NUM_STAGES = spm_pkg::NUM_STAGES_DEF,
  parameter int COUNT_BITS = spm_pkg::COUNT_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [spm_pkg::THRESH_W-1:0]  anomaly_threshold,
  input  logic                          mid_valid,
  input  spm_pkg::spm_mid_t             mid_item,
  output logic                          mid_ready,
  output logic                          res_valid,
  output spm_pkg::spm_result_t          res_item,
  input  logic                          res_ready
);

  localparam int IDX_BITS = (NUM_STAGES > 1) ? $clog2(NUM_STAGES) : 1;
  localparam int SW       = spm_pkg::STAGE_W;
  localparam int W        = spm_pkg::STAMP_W;

  logic [COUNT_BITS-1:0] anom_cnt_r [NUM_STAGES];

  logic                 res_valid_r;
  spm_pkg::spm_result_t res_r;
  spm_pkg::spm_result_t res_nxt;

  logic                   take;
  logic [SW+IDX_BITS-1:0] idx_wide;
  logic [IDX_BITS-1:0]    sel;
  logic [W:0]             ld_x, wd_x, e_lw, e_wl;
  logic [W-1:0]           diff;
  logic                   over;
  logic                   anomaly;
  logic [COUNT_BITS-1:0]  cnt_cur;
  logic [COUNT_BITS-1:0]  cnt_nxt;
  logic [COUNT_BITS+31:0] cnt_ext;

  // handshake
  assign mid_ready = !res_valid_r || res_ready;
  assign take      = mid_valid && mid_ready;
  assign res_valid = res_valid_r;
  assign res_item  = res_r;

  // exact gap between local and wall deltas, then threshold test
  always_comb begin
    idx_wide = {{IDX_BITS{1'b0}}, mid_item.stage_index};
    sel      = idx_wide[IDX_BITS-1:0];
    ld_x     = {mid_item.local_delta[W-1], mid_item.local_delta};
    wd_x     = {mid_item.wall_time_delta[W-1], mid_item.wall_time_delta};
    e_lw     = ld_x - wd_x;
    e_wl     = wd_x - ld_x;
    diff     = e_lw[W] ? e_wl[W-1:0] : e_lw[W-1:0];
    over     = diff > {32'd0, anomaly_threshold};
    anomaly  = mid_item.obs && mid_item.priors_nz &&
               (over || (mid_item.local_delta == '0) || mid_item.local_delta[W-1]);
    cnt_cur  = anom_cnt_r[sel];
    cnt_nxt  = anomaly ? ((&cnt_cur) ? cnt_cur : cnt_cur + 1'b1) : cnt_cur;
    cnt_ext  = {32'd0, cnt_nxt};
  end

  // result transaction, all zero unless a record was updated
  always_comb begin
    res_nxt = '0;
    if (mid_item.obs) begin
      res_nxt.accepted              = 1'b1;
      res_nxt.local_delta           = mid_item.local_delta;
      res_nxt.wall_time_delta       = mid_item.wall_time_delta;
      res_nxt.source_stamp_delta    = mid_item.source_stamp_delta;
      res_nxt.source_timecode_delta = mid_item.source_timecode_delta;
      res_nxt.pacing_anomaly        = anomaly;
      res_nxt.observation_total     = mid_item.observation_total;
      res_nxt.anomaly_total         = (|cnt_ext[COUNT_BITS+31:32]) ? '1 : cnt_ext[31:0];
    end
  end

  // anomaly counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_STAGES; i++) begin
        anom_cnt_r[i] <= '0;
      end
    end else if (take && mid_item.clear) begin
      for (int i = 0; i < NUM_STAGES; i++) begin
        anom_cnt_r[i] <= '0;
      end
    end else if (take && anomaly) begin
      anom_cnt_r[sel] <= cnt_nxt;
    end
  end

  // result valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_valid_r <= 1'b0;
    end else if (take) begin
      res_valid_r <= 1'b1;
    end else if (res_ready) begin
      res_valid_r <= 1'b0;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (take) begin
      res_r <= res_nxt;
    end
  end

endmodule

FILE: hw/rtl/stage_pacing_monitor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stage_pacing_monitor: per-stage timestamp pacing monitor
// Path: a taken input transaction moves through the input register, then
// the delta stage and result registers, before its result is valid.
// Throughput: one transaction per cycle unless out_ready stalls, set by the
// record read/update in the delta stage and the anomaly counter update.
// Reset: synchronous active low; clears all stage records and counters,
// capture disabled, threshold 2000000 ns.
// ----------------------------------------------------------------------------
module stage_pacing_monitor #(
  parameter int NUM_STAGES = spm_pkg::NUM_STAGES_DEF,
  parameter int COUNT_BITS = spm_pkg::COUNT_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // configuration writes
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [spm_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [spm_pkg::THRESH_W-1:0]      cfg_data,
  // input transactions
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              in_req_type,
  input  logic [spm_pkg::STAGE_W-1:0]       in_stage_index,
  input  logic signed [spm_pkg::STAMP_W-1:0] in_source_stamp,
  input  logic signed [spm_pkg::STAMP_W-1:0] in_source_timecode,
  input  logic [spm_pkg::STAMP_W-1:0]       in_local_stamp,
  input  logic [spm_pkg::STAMP_W-1:0]       in_wall_time,
  // result transactions
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              out_accepted,
  output logic signed [spm_pkg::STAMP_W-1:0] out_local_delta,
  output logic signed [spm_pkg::STAMP_W-1:0] out_wall_time_delta,
  output logic signed [spm_pkg::STAMP_W-1:0] out_source_stamp_delta,
  output logic signed [spm_pkg::STAMP_W-1:0] out_source_timecode_delta,
  output logic                              out_pacing_anomaly,
  output logic [spm_pkg::TOTAL_W-1:0]       out_observation_total,
  output logic [spm_pkg::TOTAL_W-1:0]       out_anomaly_total
);

  logic                         capture_en_r;
  logic [spm_pkg::THRESH_W-1:0] threshold_r;

  logic               in_valid_r;
  spm_pkg::spm_item_t in_item_r;
  spm_pkg::spm_item_t in_item_nxt;
  logic               a_ready;

  logic                 mid_valid;
  spm_pkg::spm_mid_t    mid_item;
  logic                 mid_ready;
  logic                 res_valid;
  spm_pkg::spm_result_t res_item;

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      capture_en_r <= 1'b0;
      threshold_r  <= spm_pkg::THRESH_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        spm_pkg::CFG_CAPTURE_ENABLE: capture_en_r <= cfg_data[0];
        spm_pkg::CFG_ANOMALY_THRESH: threshold_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // input register
  assign in_ready = !in_valid_r || a_ready;

  always_comb begin
    in_item_nxt.req_type        = in_req_type;
    in_item_nxt.stage_index     = in_stage_index;
    in_item_nxt.source_stamp    = $unsigned(in_source_stamp);
    in_item_nxt.source_timecode = $unsigned(in_source_timecode);
    in_item_nxt.local_stamp     = in_local_stamp;
    in_item_nxt.wall_time       = in_wall_time;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      in_valid_r <= 1'b1;
    end else if (a_ready) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_item_r <= in_item_nxt;
    end
  end

  // delta stage
  spm_delta_stage #(
    .NUM_STAGES (NUM_STAGES),
    .COUNT_BITS (COUNT_BITS)
  ) u_delta (
    .clk            (clk),
    .rst_n          (rst_n),
    .capture_enable (capture_en_r),
    .in_valid       (in_valid_r),
    .in_item        (in_item_r),
    .in_ready       (a_ready),
    .mid_valid      (mid_valid),
    .mid_item       (mid_item),
    .mid_ready      (mid_ready)
  );

  // anomaly stage
  spm_anomaly_stage #(
    .NUM_STAGES (NUM_STAGES),
    .COUNT_BITS (COUNT_BITS)
  ) u_anomaly (
    .clk               (clk),
    .rst_n             (rst_n),
    .anomaly_threshold (threshold_r),
    .mid_valid         (mid_valid),
    .mid_item          (mid_item),
    .mid_ready         (mid_ready),
    .res_valid         (res_valid),
    .res_item          (res_item),
    .res_ready         (out_ready)
  );

  // result ports
  assign out_valid                 = res_valid;
  assign out_accepted              = res_item.accepted;
  assign out_local_delta           = $signed(res_item.local_delta);
  assign out_wall_time_delta       = $signed(res_item.wall_time_delta);
  assign out_source_stamp_delta    = $signed(res_item.source_stamp_delta);
  assign out_source_timecode_delta = $signed(res_item.source_timecode_delta);
  assign out_pacing_anomaly        = res_item.pacing_anomaly;
  assign out_observation_total     = res_item.observation_total;
  assign out_anomaly_total         = res_item.anomaly_total;

endmodule
